// ===== rtl/swarq_pkg.sv =====
// Shared types and constants of the sliding-window ARQ sender core.
package swarq_pkg;

	localparam int SEQ_W           = 32;
	localparam int OP_W            = 2;
	localparam int PT_W            = 3;
	localparam int KIND_W          = 3;
	localparam int WINDOW_SLOTS_DEF = 8;
	localparam int MOD_STEP_BITS   = 4;

	typedef enum logic [OP_W-1:0] {
		OP_FILL = 2'd0,
		OP_ACK  = 2'd1,
		OP_NACK = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [PT_W-1:0] {
		PT_START = 3'd0,
		PT_DATA  = 3'd1,
		PT_ACK   = 3'd2,
		PT_END   = 3'd3,
		PT_NACK  = 3'd4
	} pkt_type_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_SEND     = 3'd0,
		KIND_RETX     = 3'd1,
		KIND_ACK_OK   = 3'd2,
		KIND_ACK_BAD  = 3'd3,
		KIND_NACK_IGN = 3'd4,
		KIND_IDLE     = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FILL,
		ST_ACK,
		ST_NACK,
		ST_NACK_RD,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/swarq_mod_unit.sv =====
// Iterative residue unit: value mod WINDOW_SLOTS, four bits per cycle.
module swarq_mod_unit #(
	parameter int WINDOW_SLOTS = swarq_pkg::WINDOW_SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [swarq_pkg::SEQ_W-1:0] value,
	output logic                      busy,
	output logic [((WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1)-1:0] rem
);

	localparam int SLOT_W  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int STEPS   = swarq_pkg::SEQ_W / swarq_pkg::MOD_STEP_BITS;
	localparam int STEP_CW = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam logic [SLOT_W:0] MODULUS = (SLOT_W + 1)'(WINDOW_SLOTS);

	logic                       busy_q;
	logic [STEP_CW-1:0]         step_q;
	logic [swarq_pkg::SEQ_W-1:0] sh_q;
	logic [SLOT_W-1:0]          rem_q;
	logic [SLOT_W-1:0]          rem_d;
	logic [SLOT_W:0]            trial;

	// shift in one bit, subtract the modulus once: the partial residue stays below it
	always_comb begin
		rem_d = rem_q;
		trial = '0;
		for (int i = 0; i < swarq_pkg::MOD_STEP_BITS; i++) begin
			trial = {rem_d, sh_q[swarq_pkg::SEQ_W-1-i]};
			if (trial >= MODULUS) begin
				trial = trial - MODULUS;
			end
			rem_d = trial[SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_CW'(1);
			if (step_q == STEP_CW'(STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= value;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= sh_q << swarq_pkg::MOD_STEP_BITS;
			rem_q <= rem_d;
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/swarq_seq_ram.sv =====
// Slot sequence memory: one write port, one registered read port.
module swarq_seq_ram #(
	parameter int WINDOW_SLOTS = swarq_pkg::WINDOW_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [((WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1)-1:0] waddr,
	input  logic [swarq_pkg::SEQ_W-1:0] wdata,
	input  logic [((WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1)-1:0] raddr,
	output logic [swarq_pkg::SEQ_W-1:0] rdata
);

	logic [swarq_pkg::SEQ_W-1:0] mem [WINDOW_SLOTS];
	logic [swarq_pkg::SEQ_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/sliding_window_arq_sender_core.sv =====
// Sliding-window ARQ sender core: sequence control, slot flags and result register.
//
//  channel   dir  handshake            word
//  in        in   in_valid / in_stall  op, pkt_type, ack_num
//  out       out  out_valid / out_stall kind, seq, window_base, done_res, last
//  cfg       in   cfg_we               cfg_data (packet_total)
//
// Fill: accept + decode, then issue one word per output load, waiting on out stalls (at most WINDOW_SLOTS).
// Ack: accept + decode, then 8 residue steps while slots are freed from the old base, one per cycle.
// Nack: accept + decode, then 8 residue steps, then one memory read.
// Residue unit (4 bits a cycle) and slot walk set the pace; one item at a time.
// Reset clears counters, busy flags and the output valid flag; slot memory has no reset.
// A stall on out holds the result register; the sequencer waits until it drains.
module sliding_window_arq_sender_core #(
	parameter int WINDOW_SLOTS = swarq_pkg::WINDOW_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [swarq_pkg::SEQ_W-1:0]  cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [swarq_pkg::OP_W-1:0]   op,
	input  logic [swarq_pkg::PT_W-1:0]   pkt_type,
	input  logic [swarq_pkg::SEQ_W-1:0]  ack_num,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [swarq_pkg::KIND_W-1:0] kind,
	output logic [swarq_pkg::SEQ_W-1:0]  seq,
	output logic [swarq_pkg::SEQ_W-1:0]  window_base,
	output logic                         done_res,
	output logic                         last
);

	localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int CNT_W  = $clog2(WINDOW_SLOTS + 1);
	localparam int SW     = swarq_pkg::SEQ_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SLOTS - 1);
	localparam int unsigned WRAP_REM = 32'hFFFF_FFFF % WINDOW_SLOTS;
	localparam logic [SLOT_W-1:0] WRAP_SLOT = SLOT_W'(WRAP_REM);
	localparam logic [SW:0] WIN_EXT = (SW + 1)'(WINDOW_SLOTS);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(WINDOW_SLOTS);
	localparam logic [SW-1:0] SEQ_MAX = '1;

	swarq_pkg::state_t state_q, state_d;

	logic [SW-1:0]           total_q;
	logic [SW-1:0]           next_q;
	logic [SW-1:0]           base_q;
	logic [SW:0]             base_end_q;
	logic [SLOT_W-1:0]       next_slot_q;
	logic [SLOT_W-1:0]       base_slot_q;
	logic [WINDOW_SLOTS-1:0] busy_q;
	logic [CNT_W-1:0]        fill_cnt_q;
	logic [CNT_W-1:0]        clr_left_q;
	logic [SLOT_W-1:0]       clr_slot_q;
	logic [SLOT_W-1:0]       slot_q;

	logic [swarq_pkg::OP_W-1:0] op_q;
	logic [swarq_pkg::PT_W-1:0] ptype_q;
	logic [SW-1:0]              num_q;
	logic [SW-1:0]              nb_q;
	swarq_pkg::kind_t           pend_kind_q;
	logic [SW-1:0]              pend_seq_q;

	logic                   res_valid_q;
	swarq_pkg::kind_t       res_kind_q;
	logic [SW-1:0]          res_seq_q;
	logic [SW-1:0]          res_base_q;
	logic                   res_done_q;
	logic                   res_last_q;

	logic                   out_ld;
	logic                   accept;
	logic                   ack_ok;
	logic                   nack_ok;
	logic [SW-1:0]          diff;
	logic                   can_cur;
	logic                   can_nxt;
	logic [SW-1:0]          nxt_seq;
	logic [SLOT_W-1:0]      nxt_slot;
	logic                   mod_start;
	logic [SW-1:0]          mod_val;
	logic                   mod_busy;
	logic [SLOT_W-1:0]      mod_rem;
	logic [SW-1:0]          ram_rdata;

	logic                   res_ld;
	logic                   fill_issue;
	logic                   clr_step;
	logic                   ack_fin;
	logic                   nack_cap;
	logic                   nack_chk;
	swarq_pkg::kind_t       res_kind_d;
	logic [SW-1:0]          res_seq_d;
	logic                   res_last_d;

	assign out_ld = !res_valid_q || !out_stall;

	// decode checks on the held word
	assign ack_ok  = (ptype_q == swarq_pkg::PT_ACK) && (num_q >= base_q) && (num_q <= total_q);
	assign nack_ok = (ptype_q == swarq_pkg::PT_NACK) && (num_q != '0) && (num_q <= total_q);
	assign diff    = num_q - base_q;
	assign mod_val = (op_q == swarq_pkg::OP_NACK) ? num_q - SW'(1) : num_q;

	// fill: this slot, and look ahead one so the last word carries its mark
	assign nxt_seq  = next_q + SW'(1);
	assign nxt_slot = (next_q == SEQ_MAX) ? WRAP_SLOT :
	                  (next_slot_q == LAST_SLOT) ? '0 : next_slot_q + SLOT_W'(1);
	assign can_cur  = ({1'b0, next_q} < base_end_q) && (next_q <= total_q) &&
	                  !busy_q[next_slot_q] && (fill_cnt_q < CNT_MAX);
	assign can_nxt  = ({1'b0, nxt_seq} < base_end_q) && (nxt_seq <= total_q) &&
	                  !busy_q[nxt_slot] && (nxt_slot != next_slot_q) &&
	                  (fill_cnt_q + CNT_W'(1) < CNT_MAX);

	swarq_mod_unit #(
		.WINDOW_SLOTS(WINDOW_SLOTS)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mod_start),
		.value (mod_val),
		.busy  (mod_busy),
		.rem   (mod_rem)
	);

	swarq_seq_ram #(
		.WINDOW_SLOTS(WINDOW_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (fill_issue),
		.waddr(next_slot_q),
		.wdata(next_q),
		.raddr(mod_rem),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swarq_pkg::ST_IDLE: begin
				if (in_valid) state_d = swarq_pkg::ST_DECODE;
			end
			swarq_pkg::ST_DECODE: begin
				case (op_q)
					swarq_pkg::OP_FILL: state_d = swarq_pkg::ST_FILL;
					swarq_pkg::OP_ACK:  state_d = ack_ok ? swarq_pkg::ST_ACK : swarq_pkg::ST_EMIT;
					swarq_pkg::OP_NACK: state_d = nack_ok ? swarq_pkg::ST_NACK : swarq_pkg::ST_EMIT;
					default:            state_d = swarq_pkg::ST_EMIT;
				endcase
			end
			swarq_pkg::ST_FILL: begin
				if (out_ld && (!can_cur || !can_nxt)) state_d = swarq_pkg::ST_IDLE;
			end
			swarq_pkg::ST_ACK: begin
				if (!mod_busy && clr_left_q == '0) state_d = swarq_pkg::ST_EMIT;
			end
			swarq_pkg::ST_NACK: begin
				if (!mod_busy) state_d = swarq_pkg::ST_NACK_RD;
			end
			swarq_pkg::ST_NACK_RD: state_d = swarq_pkg::ST_EMIT;
			swarq_pkg::ST_EMIT: begin
				if (out_ld) state_d = swarq_pkg::ST_IDLE;
			end
			default: state_d = swarq_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		accept     = 1'b0;
		mod_start  = 1'b0;
		res_ld     = 1'b0;
		fill_issue = 1'b0;
		clr_step   = 1'b0;
		ack_fin    = 1'b0;
		nack_cap   = 1'b0;
		nack_chk   = 1'b0;
		res_kind_d = pend_kind_q;
		res_seq_d  = pend_seq_q;
		res_last_d = 1'b1;
		unique case (state_q)
			swarq_pkg::ST_IDLE: accept = in_valid;
			swarq_pkg::ST_DECODE: begin
				mod_start = ((op_q == swarq_pkg::OP_ACK) && ack_ok) ||
				            ((op_q == swarq_pkg::OP_NACK) && nack_ok);
			end
			swarq_pkg::ST_FILL: begin
				res_ld     = out_ld;
				fill_issue = out_ld && can_cur;
				res_kind_d = can_cur ? swarq_pkg::KIND_SEND : swarq_pkg::KIND_IDLE;
				res_seq_d  = can_cur ? next_q : '0;
				res_last_d = !can_cur || !can_nxt;
			end
			swarq_pkg::ST_ACK: begin
				clr_step = (clr_left_q != '0);
				ack_fin  = !mod_busy && (clr_left_q == '0);
			end
			swarq_pkg::ST_NACK:    nack_cap = !mod_busy;
			swarq_pkg::ST_NACK_RD: nack_chk = 1'b1;
			swarq_pkg::ST_EMIT:    res_ld = out_ld;
			default: ;
		endcase
	end

	assign in_stall = (state_q != swarq_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swarq_pkg::ST_IDLE;
			total_q     <= SW'(1);
			next_q      <= SW'(1);
			base_q      <= SW'(1);
			base_end_q  <= (SW + 1)'(1) + WIN_EXT;
			next_slot_q <= '0;
			base_slot_q <= '0;
			busy_q      <= '0;
			fill_cnt_q  <= '0;
			clr_left_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				total_q <= cfg_data;
			end
			if (state_q == swarq_pkg::ST_DECODE) begin
				fill_cnt_q <= '0;
				if (diff >= SW'(WINDOW_SLOTS - 1)) begin
					clr_left_q <= CNT_MAX;
				end else begin
					clr_left_q <= CNT_W'(diff) + CNT_W'(1);
				end
			end
			if (fill_issue) begin
				busy_q[next_slot_q] <= 1'b1;
				next_q              <= nxt_seq;
				next_slot_q         <= nxt_slot;
				fill_cnt_q          <= fill_cnt_q + CNT_W'(1);
			end
			// free one slot a cycle from the old base
			if (clr_step) begin
				busy_q[clr_slot_q] <= 1'b0;
				clr_left_q         <= clr_left_q - CNT_W'(1);
			end
			if (ack_fin) begin
				base_q      <= nb_q;
				base_slot_q <= mod_rem;
				base_end_q  <= {1'b0, nb_q} + WIN_EXT;
			end
			if (res_ld) begin
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			ptype_q <= pkt_type;
			num_q   <= ack_num;
		end
		if (state_q == swarq_pkg::ST_DECODE) begin
			nb_q       <= num_q + SW'(1);
			clr_slot_q <= base_slot_q;
			pend_seq_q <= '0;
			case (op_q)
				swarq_pkg::OP_ACK:  pend_kind_q <= ack_ok ? swarq_pkg::KIND_ACK_OK
				                                          : swarq_pkg::KIND_ACK_BAD;
				swarq_pkg::OP_NACK: pend_kind_q <= swarq_pkg::KIND_NACK_IGN;
				default:            pend_kind_q <= swarq_pkg::KIND_IDLE;
			endcase
		end
		if (clr_step) begin
			clr_slot_q <= (clr_slot_q == LAST_SLOT) ? '0 : clr_slot_q + SLOT_W'(1);
		end
		if (nack_cap) begin
			slot_q <= mod_rem;
		end
		// memory word for slot_q arrives now
		if (nack_chk && busy_q[slot_q]) begin
			pend_kind_q <= swarq_pkg::KIND_RETX;
			pend_seq_q  <= ram_rdata;
		end
		if (res_ld) begin
			res_kind_q <= res_kind_d;
			res_seq_q  <= res_seq_d;
			res_base_q <= base_q;
			res_done_q <= (base_q > total_q);
			res_last_q <= res_last_d;
		end
	end

	assign out_valid   = res_valid_q;
	assign kind        = res_kind_q;
	assign seq         = res_seq_q;
	assign window_base = res_base_q;
	assign done_res    = res_done_q;
	assign last        = res_last_q;

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ld && res_last_d) |=> (state_q == swarq_pkg::ST_IDLE))
		else $error("item did not end after its final word");

	a_mod_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swarq_pkg::ST_IDLE) |-> !mod_busy)
		else $error("residue unit busy while sequencer idle");

	a_busy_growth: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(busy_q) <= $countones($past(busy_q)) + 1)
		else $error("more than one slot taken in a cycle");

	a_nack_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swarq_pkg::ST_NACK_RD) |-> ($past(state_q) == swarq_pkg::ST_NACK))
		else $error("slot read without a residue");

endmodule
